@@ design/fxq_pkg.sv @@
// fxq_pkg: shared types and constants for the float-to-fixed quantizer
// no dependencies
`default_nettype none

package fxq_pkg;

    localparam int OUT_BITS = 16;
    localparam int FB_W = 4;
    localparam int SB_W = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRACTION_BITS   = 2'd0,
        REG_SATURATION_BITS = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [FB_W-1:0] fraction_bits;
        logic [SB_W-1:0] saturation_bits;
    } fxq_cfg_t;

endpackage

`default_nettype wire

@@ design/fxq_cfg.sv @@
// fxq_cfg: configuration register file
// depends on fxq_pkg
`default_nettype none

module fxq_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fxq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fxq_pkg::CFG_DATA_W-1:0] cfg_data,
    output fxq_pkg::fxq_cfg_t                   cfg
);
    import fxq_pkg::*;

    fxq_cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fraction_bits   <= '0;
            cfg_reg.saturation_bits <= SB_W'(16);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_FRACTION_BITS:   cfg_reg.fraction_bits   <= cfg_data[FB_W-1:0];
                REG_SATURATION_BITS: cfg_reg.saturation_bits <= cfg_data[SB_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

@@ design/fxq_core.sv @@
// fxq_core: combinational scale, round and symmetric saturate of one binary32 sample
// depends on fxq_pkg
`default_nettype none

module fxq_core (
    input  wire logic [31:0]                  sample_bits,
    input  wire fxq_pkg::fxq_cfg_t            cfg,
    output logic signed [fxq_pkg::OUT_BITS-1:0] quantized
);
    import fxq_pkg::*;

    logic                neg;
    logic [7:0]          expo;
    logic [22:0]         frac;
    logic [23:0]         mant;
    logic [SB_W-1:0]     n_eff;
    logic [OUT_BITS-1:0] limit;
    logic signed [9:0]   sh;
    logic [7:0]          rs;
    logic [39:0]         wide;
    logic [24:0]         rnd;
    logic [OUT_BITS-1:0] mag;

    always_comb
    begin
        neg  = sample_bits[31];
        expo = sample_bits[30:23];
        frac = sample_bits[22:0];
        mant = (expo == 8'd0) ? {1'b0, frac} : {1'b1, frac};

        // clamp saturation width to 2..OUT_BITS
        if (cfg.saturation_bits < SB_W'(2))
            n_eff = SB_W'(2);
        else if (cfg.saturation_bits > SB_W'(OUT_BITS))
            n_eff = SB_W'(OUT_BITS);
        else
            n_eff = cfg.saturation_bits;
        limit = (OUT_BITS'(1) << (n_eff - SB_W'(1))) - OUT_BITS'(1);

        // subnormals share the exponent of the smallest normal
        sh = $signed({2'b00, (expo == 8'd0) ? 8'd1 : expo}) - 10'sd150
             + $signed({6'b0, cfg.fraction_bits});
        rs = 8'(-sh);
        wide = 40'(mant) << sh[3:0];
        rnd = '0;

        if (expo == 8'hFF)
            mag = (frac != 23'd0) ? '0 : limit;
        else if (mant == 24'd0)
            mag = '0;
        else if (sh >= 10'sd0)
        begin
            if (sh > 10'sd15 || wide > 40'(limit))
                mag = limit;
            else
                mag = wide[OUT_BITS-1:0];
        end
        else if (rs > 8'd25)
            mag = '0;
        else
        begin
            rnd = ({1'b0, mant} + (25'd1 << (rs[4:0] - 5'd1))) >> rs[4:0];
            mag = (rnd > 25'(limit)) ? limit : rnd[OUT_BITS-1:0];
        end

        quantized = neg ? $signed(-mag) : $signed(mag);
    end

endmodule

`default_nettype wire

@@ design/float_to_fixed_quantizer.sv @@
// float_to_fixed_quantizer: top level, binary32 sample in, symmetric saturated fixed point out
// depends on fxq_pkg, fxq_cfg, fxq_core
// path: input transaction to result valid through the input register, then the result register
// throughput: one transaction per cycle while out_stall is low; set by the single pass between the two registers
// reset: asynchronous active low, clears both valid flags, fraction_bits to 0, saturation_bits to 16
`default_nettype none

module float_to_fixed_quantizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input sample channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [31:0]                    sample_bits,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [fxq_pkg::OUT_BITS-1:0] quantized,
    // configuration write channel
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [fxq_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fxq_pkg::CFG_DATA_W-1:0] cfg_data
);
    import fxq_pkg::*;

    fxq_cfg_t cfg;

    // input stage
    logic        s1_valid_reg;
    logic [31:0] s1_sample_reg;
    // result stage
    logic                       out_valid_reg;
    logic signed [OUT_BITS-1:0] out_q_reg;
    logic signed [OUT_BITS-1:0] q_next;

    logic advance;
    logic in_take;

    fxq_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fxq_core u_core (
        .sample_bits (s1_sample_reg),
        .cfg         (cfg),
        .quantized   (q_next)
    );

    // result register moves whenever it is empty or being taken
    assign advance   = !out_valid_reg || !out_stall;
    // input register refills when it is empty or empties into the result register
    assign in_stall  = s1_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign quantized = out_q_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                out_valid_reg <= s1_valid_reg;
            if (advance || !s1_valid_reg)
                s1_valid_reg <= in_take;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
            s1_sample_reg <= sample_bits;
        if (advance && s1_valid_reg)
            out_q_reg <= q_next;
    end

endmodule

`default_nettype wire

@@ design/fxq_checker.sv @@
// fxq_checker: port-level assertions for float_to_fixed_quantizer, with bind
// depends on fxq_pkg and float_to_fixed_quantizer
`default_nettype none

module fxq_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [fxq_pkg::OUT_BITS-1:0]   quantized,
    input wire logic                           cfg_valid,
    input wire logic                           cfg_ready
);
    import fxq_pkg::*;

    // a stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quantized))
        else $error("stalled result changed");

    // most negative code never appears
    a_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quantized != {1'b1, {(OUT_BITS-1){1'b0}}})
        else $error("most negative code produced");

    // an accepted transaction reaches the output when out_stall is low while it sits in the input register
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
        else $error("accepted transaction lost");

    // configuration writes never wait
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind float_to_fixed_quantizer fxq_checker u_fxq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quantized (quantized),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

`default_nettype wire
